/* src/pspd_pkg.sv */
`default_nettype none

package pspd_pkg;

    localparam int COORD_BITS = 24;
    localparam int DW  = COORD_BITS + 1;
    localparam int LW  = 2 * DW;
    localparam int NW  = 3 * DW;
    localparam int QW  = DW;
    localparam int RW  = DW;
    localparam int SW  = 2 * DW;
    localparam int RMW = DW + 2;
    localparam int LATENCY = 11 + QW + RW;

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_DEGEN   = 2'd2
    } status_t;

    typedef struct packed {
        logic [LW-1:0] den;
        logic [LW-1:0] rem_x;
        logic [LW-1:0] rem_y;
        logic [QW-1:0] num_x;
        logic [QW-1:0] num_y;
        logic [QW-1:0] quo_x;
        logic [QW-1:0] quo_y;
    } div_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [RW-1:0]  root;
        logic [SW-1:0]  rad;
    } sq_t;

    typedef struct packed {
        status_t                status;
        logic                   neg_x;
        logic                   neg_y;
        logic [COORD_BITS-1:0]  ax;
        logic [COORD_BITS-1:0]  ay;
        logic [COORD_BITS-1:0]  qx;
        logic [COORD_BITS-1:0]  qy;
    } side1_t;

    typedef struct packed {
        status_t                status;
        logic [COORD_BITS-1:0]  fx;
        logic [COORD_BITS-1:0]  fy;
    } side2_t;

endpackage

`default_nettype wire

/* src/point_segment_projection_distance_core.sv */
// Channel | Signals                                           | Handshake
// input   | seg_start_x/y, seg_end_x/y, point_x/y             | start & !busy
// result  | status, foot_x, foot_y, distance                  | done, one cycle
//
// One item per cycle; busy stays low. The divider chain has one cell per quotient
// bit, and the root chain has one cell per root bit.
// Reset clears the valid bits of every stage; items in flight are dropped.
// The receiver cannot stall: each result shows for one cycle with done high.
`default_nettype none

module point_segment_projection_distance_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] seg_start_x,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] seg_start_y,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] seg_end_x,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] seg_end_y,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] point_x,
    input  wire logic signed [pspd_pkg::COORD_BITS-1:0] point_y,
    output logic                                     done,
    output logic [1:0]                               status,
    output logic signed [pspd_pkg::COORD_BITS-1:0]   foot_x,
    output logic signed [pspd_pkg::COORD_BITS-1:0]   foot_y,
    output logic [pspd_pkg::RW-1:0]                  distance
);

    localparam int C  = pspd_pkg::COORD_BITS;
    localparam int DW = pspd_pkg::DW;
    localparam int LW = pspd_pkg::LW;
    localparam int NW = pspd_pkg::NW;
    localparam int QW = pspd_pkg::QW;
    localparam int RW = pspd_pkg::RW;

    // stage A: differences
    logic                 a_valid_reg;
    logic [C-1:0]         a_ax_reg, a_ay_reg, a_qx_reg, a_qy_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg, a_px_reg, a_py_reg;
    logic signed [DW-1:0] a_dx_next, a_dy_next, a_px_next, a_py_next;

    // stage B: products
    logic                 b_valid_reg;
    logic [C-1:0]         b_ax_reg, b_ay_reg, b_qx_reg, b_qy_reg;
    logic signed [LW-1:0] b_pxx_reg, b_pyy_reg, b_lxx_reg, b_lyy_reg;
    logic [DW-1:0]        b_mx_reg, b_my_reg;
    logic                 b_nx_reg, b_ny_reg;

    // stage C: dot, len2, status
    logic                 c_valid_reg;
    logic [C-1:0]         c_ax_reg, c_ay_reg, c_qx_reg, c_qy_reg;
    logic [LW-1:0]        c_dot_reg, c_len_reg;
    logic [DW-1:0]        c_mx_reg, c_my_reg;
    logic                 c_nx_reg, c_ny_reg;
    pspd_pkg::status_t    c_status_reg, c_status_next;
    logic signed [LW:0]   c_dot_next;
    logic [LW-1:0]        c_len_next;

    // stage D: partial products
    logic                 d_valid_reg;
    logic [LW-1:0]        d_xlo_reg, d_xhi_reg, d_ylo_reg, d_yhi_reg, d_len_reg;
    pspd_pkg::side1_t     d_side_reg;

    // stage E: numerators
    logic                 e_valid_reg;
    pspd_pkg::div_t       e_div_reg, e_div_next;
    logic [NW-1:0]        e_numx, e_numy;

    // divider chain
    logic                 div_valid [QW+1];
    pspd_pkg::div_t       div_data  [QW+1];
    pspd_pkg::side1_t     side1_reg [QW+1];

    // stage R: rounding
    logic                 r_valid_reg;
    logic [QW-1:0]        r_qx_reg, r_qy_reg, r_qx_next, r_qy_next;
    pspd_pkg::side1_t     r_side_reg;

    // stage F: foot
    logic                 f_valid_reg;
    pspd_pkg::side2_t     f_side_reg, f_side_next;
    logic [C-1:0]         f_qx_reg, f_qy_reg;

    // stage G: error vector
    logic                 g_valid_reg;
    pspd_pkg::side2_t     g_side_reg;
    logic signed [DW-1:0] g_ex_reg, g_ey_reg;

    // stage H: squares
    logic                 h_valid_reg;
    pspd_pkg::side2_t     h_side_reg;
    logic signed [LW-1:0] h_sx_reg, h_sy_reg;

    // root chain
    logic                 sq_valid  [RW+1];
    pspd_pkg::sq_t        sq_data   [RW+1];
    pspd_pkg::side2_t     side2_reg [RW+1];
    pspd_pkg::sq_t        i_sq_next;

    // output
    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [C-1:0]         foot_x_reg, foot_y_reg;
    logic [RW-1:0]        dist_reg;

    assign busy = 1'b0;

    always_comb
    begin
        a_dx_next = $signed({seg_end_x[C-1], seg_end_x}) - $signed({seg_start_x[C-1], seg_start_x});
        a_dy_next = $signed({seg_end_y[C-1], seg_end_y}) - $signed({seg_start_y[C-1], seg_start_y});
        a_px_next = $signed({point_x[C-1], point_x}) - $signed({seg_start_x[C-1], seg_start_x});
        a_py_next = $signed({point_y[C-1], point_y}) - $signed({seg_start_y[C-1], seg_start_y});
    end

    always_comb
    begin
        c_dot_next = $signed({b_pxx_reg[LW-1], b_pxx_reg})
                   + $signed({b_pyy_reg[LW-1], b_pyy_reg});
        c_len_next = b_lxx_reg + b_lyy_reg;
        if (c_len_next == '0)
        begin
            c_status_next = pspd_pkg::ST_DEGEN;
        end
        else if (c_dot_next[LW] || (c_dot_next[LW-1:0] > c_len_next))
        begin
            c_status_next = pspd_pkg::ST_OUTSIDE;
        end
        else
        begin
            c_status_next = pspd_pkg::ST_INSIDE;
        end
    end

    always_comb
    begin
        e_numx = {d_xhi_reg, {DW{1'b0}}} + {{DW{1'b0}}, d_xlo_reg};
        e_numy = {d_yhi_reg, {DW{1'b0}}} + {{DW{1'b0}}, d_ylo_reg};
        e_div_next.den   = d_len_reg;
        e_div_next.rem_x = e_numx[NW-1:QW];
        e_div_next.rem_y = e_numy[NW-1:QW];
        e_div_next.num_x = e_numx[QW-1:0];
        e_div_next.num_y = e_numy[QW-1:0];
        e_div_next.quo_x = '0;
        e_div_next.quo_y = '0;
    end

    always_comb
    begin
        r_qx_next = div_data[QW].quo_x
                  + {{(QW-1){1'b0}}, ({div_data[QW].rem_x, 1'b0} >= {1'b0, div_data[QW].den})};
        r_qy_next = div_data[QW].quo_y
                  + {{(QW-1){1'b0}}, ({div_data[QW].rem_y, 1'b0} >= {1'b0, div_data[QW].den})};
    end

    always_comb
    begin
        f_side_next.status = r_side_reg.status;
        f_side_next.fx = r_side_reg.ax + (r_side_reg.neg_x ? (~r_qx_reg[C-1:0] + 1'b1)
                                                           : r_qx_reg[C-1:0]);
        f_side_next.fy = r_side_reg.ay + (r_side_reg.neg_y ? (~r_qy_reg[C-1:0] + 1'b1)
                                                           : r_qy_reg[C-1:0]);
    end

    always_comb
    begin
        i_sq_next.rem  = '0;
        i_sq_next.root = '0;
        i_sq_next.rad  = h_sx_reg + h_sy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            r_valid_reg <= div_valid[QW];
            f_valid_reg <= r_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            done_reg    <= sq_valid[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        a_ax_reg <= seg_start_x;
        a_ay_reg <= seg_start_y;
        a_qx_reg <= point_x;
        a_qy_reg <= point_y;
        a_dx_reg <= a_dx_next;
        a_dy_reg <= a_dy_next;
        a_px_reg <= a_px_next;
        a_py_reg <= a_py_next;

        b_ax_reg  <= a_ax_reg;
        b_ay_reg  <= a_ay_reg;
        b_qx_reg  <= a_qx_reg;
        b_qy_reg  <= a_qy_reg;
        b_pxx_reg <= a_dx_reg * a_px_reg;
        b_pyy_reg <= a_dy_reg * a_py_reg;
        b_lxx_reg <= a_dx_reg * a_dx_reg;
        b_lyy_reg <= a_dy_reg * a_dy_reg;
        b_mx_reg  <= a_dx_reg[DW-1] ? DW'(-a_dx_reg) : DW'(a_dx_reg);
        b_my_reg  <= a_dy_reg[DW-1] ? DW'(-a_dy_reg) : DW'(a_dy_reg);
        b_nx_reg  <= a_dx_reg[DW-1];
        b_ny_reg  <= a_dy_reg[DW-1];

        c_ax_reg     <= b_ax_reg;
        c_ay_reg     <= b_ay_reg;
        c_qx_reg     <= b_qx_reg;
        c_qy_reg     <= b_qy_reg;
        c_dot_reg    <= c_dot_next[LW-1:0];
        c_len_reg    <= c_len_next;
        c_mx_reg     <= b_mx_reg;
        c_my_reg     <= b_my_reg;
        c_nx_reg     <= b_nx_reg;
        c_ny_reg     <= b_ny_reg;
        c_status_reg <= c_status_next;

        d_xlo_reg         <= c_dot_reg[DW-1:0] * c_mx_reg;
        d_xhi_reg         <= c_dot_reg[LW-1:DW] * c_mx_reg;
        d_ylo_reg         <= c_dot_reg[DW-1:0] * c_my_reg;
        d_yhi_reg         <= c_dot_reg[LW-1:DW] * c_my_reg;
        d_len_reg         <= c_len_reg;
        d_side_reg.status <= c_status_reg;
        d_side_reg.neg_x  <= c_nx_reg;
        d_side_reg.neg_y  <= c_ny_reg;
        d_side_reg.ax     <= c_ax_reg;
        d_side_reg.ay     <= c_ay_reg;
        d_side_reg.qx     <= c_qx_reg;
        d_side_reg.qy     <= c_qy_reg;

        e_div_reg    <= e_div_next;
        side1_reg[0] <= d_side_reg;
        for (int i = 1; i <= QW; i++)
        begin
            side1_reg[i] <= side1_reg[i-1];
        end

        r_qx_reg   <= r_qx_next;
        r_qy_reg   <= r_qy_next;
        r_side_reg <= side1_reg[QW];

        f_side_reg <= f_side_next;
        f_qx_reg   <= r_side_reg.qx;
        f_qy_reg   <= r_side_reg.qy;

        g_side_reg <= f_side_reg;
        g_ex_reg   <= $signed({f_qx_reg[C-1], f_qx_reg}) - $signed({f_side_reg.fx[C-1], f_side_reg.fx});
        g_ey_reg   <= $signed({f_qy_reg[C-1], f_qy_reg}) - $signed({f_side_reg.fy[C-1], f_side_reg.fy});

        h_side_reg <= g_side_reg;
        h_sx_reg   <= g_ex_reg * g_ex_reg;
        h_sy_reg   <= g_ey_reg * g_ey_reg;

        side2_reg[0] <= h_side_reg;
        for (int i = 1; i <= RW; i++)
        begin
            side2_reg[i] <= side2_reg[i-1];
        end

        status_reg <= side2_reg[RW].status;
        if (side2_reg[RW].status == pspd_pkg::ST_INSIDE)
        begin
            foot_x_reg <= side2_reg[RW].fx;
            foot_y_reg <= side2_reg[RW].fy;
            dist_reg   <= sq_data[RW].root;
        end
        else
        begin
            foot_x_reg <= '0;
            foot_y_reg <= '0;
            dist_reg   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid[0] <= 1'b0;
        end
        else
        begin
            sq_valid[0] <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_data[0] <= i_sq_next;
    end

    assign div_valid[0] = e_valid_reg;
    assign div_data[0]  = e_div_reg;

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        pspd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_d      (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_d     (div_data[g+1])
        );
    end

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        pspd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_d      (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_d     (sq_data[g+1])
        );
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign foot_x   = foot_x_reg;
    assign foot_y   = foot_y_reg;
    assign distance = dist_reg;

endmodule

`default_nettype wire

/* src/pspd_div_cell.sv */
`default_nettype none

module pspd_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire pspd_pkg::div_t in_d,
    output logic               out_valid,
    output pspd_pkg::div_t     out_d
);

    logic [pspd_pkg::LW:0] trial_x, trial_y, diff_x, diff_y, den_ext;
    logic                  take_x, take_y;
    logic                  valid_reg;
    pspd_pkg::div_t        data_reg, data_next;

    always_comb
    begin
        den_ext = {1'b0, in_d.den};
        trial_x = {in_d.rem_x, in_d.num_x[pspd_pkg::QW-1]};
        trial_y = {in_d.rem_y, in_d.num_y[pspd_pkg::QW-1]};
        diff_x  = trial_x - den_ext;
        diff_y  = trial_y - den_ext;
        take_x  = trial_x >= den_ext;
        take_y  = trial_y >= den_ext;
        data_next.den   = in_d.den;
        data_next.rem_x = take_x ? diff_x[pspd_pkg::LW-1:0] : trial_x[pspd_pkg::LW-1:0];
        data_next.rem_y = take_y ? diff_y[pspd_pkg::LW-1:0] : trial_y[pspd_pkg::LW-1:0];
        data_next.num_x = {in_d.num_x[pspd_pkg::QW-2:0], 1'b0};
        data_next.num_y = {in_d.num_y[pspd_pkg::QW-2:0], 1'b0};
        data_next.quo_x = {in_d.quo_x[pspd_pkg::QW-2:0], take_x};
        data_next.quo_y = {in_d.quo_y[pspd_pkg::QW-2:0], take_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_d     = data_reg;

endmodule

`default_nettype wire

/* src/pspd_sqrt_cell.sv */
`default_nettype none

module pspd_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire pspd_pkg::sq_t in_d,
    output logic               out_valid,
    output pspd_pkg::sq_t      out_d
);

    logic [pspd_pkg::RMW+1:0] trial, cand, diff;
    logic                     take;
    logic                     valid_reg;
    pspd_pkg::sq_t            data_reg, data_next;

    always_comb
    begin
        trial = {in_d.rem, in_d.rad[pspd_pkg::SW-1:pspd_pkg::SW-2]};
        cand  = {{(pspd_pkg::RMW - pspd_pkg::RW){1'b0}}, in_d.root, 2'b01};
        diff  = trial - cand;
        take  = trial >= cand;
        data_next.rem  = take ? diff[pspd_pkg::RMW-1:0] : trial[pspd_pkg::RMW-1:0];
        data_next.root = {in_d.root[pspd_pkg::RW-2:0], take};
        data_next.rad  = {in_d.rad[pspd_pkg::SW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_d     = data_reg;

endmodule

`default_nettype wire

/* src/pspd_checker.sv */
`default_nettype none

module pspd_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               done,
    input wire logic [1:0]                         status,
    input wire logic [pspd_pkg::COORD_BITS-1:0]    foot_x,
    input wire logic [pspd_pkg::COORD_BITS-1:0]    foot_y,
    input wire logic [pspd_pkg::RW-1:0]            distance
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, pspd_pkg::LATENCY))
        else $error("result without matching item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == pspd_pkg::ST_INSIDE || status == pspd_pkg::ST_OUTSIDE
                  || status == pspd_pkg::ST_DEGEN))
        else $error("bad status code");

    a_zero_when_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != pspd_pkg::ST_INSIDE) |->
        (foot_x == '0 && foot_y == '0 && distance == '0))
        else $error("nonzero result on non-inside status");

endmodule

bind point_segment_projection_distance_core pspd_checker u_pspd_checker (.*);

`default_nettype wire
